// ----- design/fihs_pkg.sv -----
package fihs_pkg;

    localparam int KEY_W    = 128;
    localparam int HALF_W   = 64;
    localparam int LIMIT_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    localparam logic [HALF_W-1:0]  HASH_ADD    = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd716;

    localparam logic [STATUS_W-1:0] STATUS_NEW  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [HALF_W-1:0] dev;
        logic [HALF_W-1:0] ino;
    } key_t;

    // queue flags seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- design/fihs_ram.sv -----
module fihs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/fihs_front.sv -----
module fihs_front #(
    parameter int CAPACITY = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [63:0]                 device_number,
    input  logic [63:0]                 inode_number,
    input  logic                        clearing,
    input  fihs_pkg::q_status_t         q_stat,
    output logic                        push,
    output fihs_pkg::key_t              push_key,
    output logic [$clog2(CAPACITY)-1:0] push_home
);

    localparam int AW = $clog2(CAPACITY);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_ADD  = 2'd1;
    localparam logic [1:0] F_HASH = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]     state_reg, state_next;
    fihs_pkg::key_t key_reg, key_next;
    logic [63:0]    sum_a_reg, sum_a_next;
    logic [63:0]    sum_b_reg, sum_b_next;
    logic [AW-1:0]  home_reg, home_next;
    logic [63:0]    mix;
    logic           accept;

    assign accept     = (state_reg == F_IDLE) && !clearing && item_valid;
    assign item_stall = (state_reg != F_IDLE) || clearing;
    assign push       = (state_reg == F_PUSH) && !q_stat.full;
    assign push_key   = key_reg;
    assign push_home  = home_reg;

    // CAPACITY must be a power of two, which this module does not enforce: home slot is the low hash bits
    assign mix = key_reg.dev ^ (sum_a_reg + sum_b_reg);

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        home_next  = home_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    key_next.dev = device_number;
                    key_next.ino = inode_number;
                    state_next   = F_ADD;
                end
            end
            F_ADD:
            begin
                sum_a_next = key_reg.ino + fihs_pkg::HASH_ADD;
                sum_b_next = (key_reg.dev << 6) + (key_reg.dev >> 2);
                state_next = F_HASH;
            end
            F_HASH:
            begin
                home_next  = mix[AW-1:0];
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        sum_a_reg <= sum_a_next;
        sum_b_reg <= sum_b_next;
        home_reg  <= home_next;
    end

endmodule

// ----- design/fihs_queue.sv -----
module fihs_queue #(
    parameter int WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    head_data,
    output fihs_pkg::q_status_t q_stat
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_push, do_pop;

    assign q_stat.full  = (cnt_reg == 2'd2);
    assign q_stat.empty = (cnt_reg == 2'd0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_data    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/fihs_back.sv -----
module fihs_back #(
    parameter int CAPACITY = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fihs_pkg::q_status_t                  q_stat,
    input  fihs_pkg::key_t                       head_key,
    input  logic [$clog2(CAPACITY)-1:0]          head_home,
    output logic                                 pop,
    output logic                                 clearing,
    input  logic [fihs_pkg::LIMIT_W-1:0]         fill_limit,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [fihs_pkg::STATUS_W-1:0]        status
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int WORD_W = fihs_pkg::KEY_W + 1;
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    localparam logic [1:0] B_CLEAR  = 2'd0;
    localparam logic [1:0] B_IDLE   = 2'd1;
    localparam logic [1:0] B_CHECK  = 2'd2;
    localparam logic [1:0] B_RESULT = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [AW-1:0]                   pos_reg, pos_next, pos_inc;
    logic [AW-1:0]                   probe_reg, probe_next;
    fihs_pkg::key_t                  key_reg, key_next;
    logic [fihs_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [fihs_pkg::STATUS_W-1:0]   pend_reg, pend_next;
    logic                            result_valid_reg, result_valid_next;
    logic [fihs_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic                            wr_en;
    logic [AW-1:0]                   waddr, raddr;
    logic [WORD_W-1:0]               wdata, rdata;
    logic                            rd_used;
    fihs_pkg::key_t                  rd_key;
    logic                            out_free;

    // slot word: occupancy mark on top of the stored key
    fihs_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CAPACITY)
    ) u_slots (
        .clk  (clk),
        .we   (wr_en),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rd_used      = rdata[WORD_W-1];
    assign rd_key       = rdata[fihs_pkg::KEY_W-1:0];
    assign pos_inc      = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
    assign out_free     = !result_valid_reg || !result_stall;
    assign clearing     = (state_reg == B_CLEAR);
    assign result_valid = result_valid_reg;
    assign status       = status_reg;

    always_comb
    begin
        state_next        = state_reg;
        pos_next          = pos_reg;
        probe_next        = probe_reg;
        key_next          = key_reg;
        count_next        = count_reg;
        pend_next         = pend_reg;
        status_next       = status_reg;
        result_valid_next = result_valid_reg && result_stall;
        wr_en             = 1'b0;
        waddr             = pos_reg;
        wdata             = {1'b1, key_reg};
        raddr             = pos_inc;
        pop               = 1'b0;
        unique case (state_reg)
            B_CLEAR:
            begin
                wr_en    = 1'b1;
                wdata    = '0;
                pos_next = pos_inc;
                if (pos_reg == LAST)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                raddr = head_home;
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    key_next   = head_key;
                    pos_next   = head_home;
                    probe_next = '0;
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                priority if (!rd_used)
                begin
                    if (count_reg >= {1'b0, fill_limit})
                    begin
                        pend_next = fihs_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        pend_next  = fihs_pkg::STATUS_NEW;
                    end
                    state_next = B_RESULT;
                end
                else if (rd_key == key_reg)
                begin
                    pend_next  = fihs_pkg::STATUS_DUP;
                    state_next = B_RESULT;
                end
                else if (probe_reg == LAST)
                begin
                    // every slot visited, none free
                    pend_next  = fihs_pkg::STATUS_FULL;
                    state_next = B_RESULT;
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    pos_next   = pos_inc;
                end
            end
            B_RESULT:
            begin
                if (out_free)
                begin
                    status_next       = pend_reg;
                    result_valid_next = 1'b1;
                    state_next        = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_CLEAR;
            pos_reg          <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pos_reg          <= pos_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg  <= probe_next;
        key_reg    <= key_next;
        pend_reg   <= pend_next;
        status_reg <= status_next;
    end

endmodule

// ----- design/file_identity_hash_set_insert_unit.sv -----
// Visited set for file identities. Each request carries a 64-bit device number
// and a 64-bit inode number; the unit hashes the pair as
// dev ^ (ino + 0x9e3779b97f4a7c15 + (dev << 6) + (dev >> 2)), keeps the low
// bits as the home slot (CAPACITY must be a power of two) and probes forward
// linearly, wrapping at the end.
// One status comes back per request, in order: 0 newly stored, 1 already
// present, 2 refused (stored count has reached fill_limit, or no free slot).
// A key already stored is reported present even when the set is full.
// fill_limit resets to 716 and may only be written while the unit is idle;
// lowering it below the stored count just refuses new keys until reset.
// After reset the unit sweeps every slot of the memory clear and holds
// item_stall high meanwhile. The front sequencer handles one request at a
// time, stepping through take, add, hash and push; the back probe engine
// pops each request, reads and checks one slot at a time, since the slot
// RAM has one registered read port, and then posts the status. A two-entry
// queue between them lets hashing overlap probing.
module file_identity_hash_set_insert_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           fill_limit_we,
    input  logic [fihs_pkg::LIMIT_W-1:0]   fill_limit_wdata,
    // request channel
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [63:0]                    device_number,
    input  logic [63:0]                    inode_number,
    // result channel
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [fihs_pkg::STATUS_W-1:0]  status
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int Q_W = fihs_pkg::KEY_W + AW;

    logic [fihs_pkg::LIMIT_W-1:0] fill_limit_reg;

    fihs_pkg::q_status_t q_stat;
    logic                push, pop, clearing;
    fihs_pkg::key_t      push_key, head_key;
    logic [AW-1:0]       push_home, head_home;
    logic [Q_W-1:0]      head_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_limit_reg <= fihs_pkg::LIMIT_RESET;
        end
        else if (fill_limit_we)
        begin
            fill_limit_reg <= fill_limit_wdata;
        end
    end

    // front: take request, hash, find home slot
    fihs_front #(
        .CAPACITY(CAPACITY)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .device_number(device_number),
        .inode_number (inode_number),
        .clearing     (clearing),
        .q_stat       (q_stat),
        .push         (push),
        .push_key     (push_key),
        .push_home    (push_home)
    );

    // key and home slot wait here for the probe engine
    fihs_queue #(
        .WIDTH(Q_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data({push_key, push_home}),
        .pop      (pop),
        .head_data(head_data),
        .q_stat   (q_stat)
    );

    assign head_key  = head_data[Q_W-1:AW];
    assign head_home = head_data[AW-1:0];

    // back: probe slots, insert, hold the result
    fihs_back #(
        .CAPACITY(CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .head_key    (head_key),
        .head_home   (head_home),
        .pop         (pop),
        .clearing    (clearing),
        .fill_limit  (fill_limit_reg),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .status      (status)
    );

endmodule

// ----- design/fihs_checker.sv -----
module fihs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_stall,
    input logic                           result_valid,
    input logic                           result_stall,
    input logic [fihs_pkg::STATUS_W-1:0]  status
);

    // held result must not move
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == fihs_pkg::STATUS_NEW ||
                          status == fihs_pkg::STATUS_DUP ||
                          status == fihs_pkg::STATUS_FULL))
        else $error("undefined status code");

    // front works one request at a time
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("request taken while front busy");

    // slot clear sweep blocks requests right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> item_stall && !result_valid)
        else $error("request or result during slot clear");

endmodule

bind file_identity_hash_set_insert_unit fihs_checker u_fihs_checker (.*);
